FILE: hw/rtl/leb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_pkg
// shared types and constants for the leb128 stream decoder
// ----------------------------------------------------------------------------
package leb_pkg;

    // decode modes, sampled on the first byte of a value
    localparam logic [1:0] MODE_U32 = 2'd0;
    localparam logic [1:0] MODE_S32 = 2'd1;
    localparam logic [1:0] MODE_S64 = 2'd2;

    // index of the longest allowed byte of a value
    localparam logic [3:0] LAST_NARROW = 4'd4;
    localparam logic [3:0] LAST_WIDE   = 4'd9;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_BITS  = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] value;
        t_status            status;
        logic [3:0]         length;
    } t_out_item;

    // decoder state carried between bytes of one value
    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  cnt;
        logic [1:0]  mode;
    } t_dec_state;

endpackage

FILE: hw/rtl/leb128_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb128_stream_decoder
// byte-serial leb128 decoder for unsigned32, signed32 and signed64 values
// ----------------------------------------------------------------------------
// a result is loaded into the result register from the input register holding its last byte
// throughput: one byte per cycle, unless a finishing byte waits on a stalled, full result
// register; bytes continuing a value cause no result and never wait on the output side
// reset (i_rst_n low, synchronous) empties both registers and clears the decoder
// state; the first byte after reset starts a new value
// ----------------------------------------------------------------------------
module leb128_stream_decoder
    import leb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // input register
    logic       r_in_valid;
    t_in_item   r_in;

    // decoder state between bytes of one value
    t_dec_state r_state;

    // result register
    logic       r_out_valid;
    t_out_item  r_out;

    t_dec_state n_state;
    logic       step_done;
    t_out_item  step_result;
    logic       in_xfer;
    logic       adv;

    leb_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_done   (step_done),
        .o_result (step_result)
    );

    // the held byte moves on when it makes no result or the result slot frees up
    assign adv        = r_in_valid && (!step_done || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register: loaded by a finishing byte, emptied by an output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && step_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && step_done) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // byte count never runs past the longest byte index
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cnt <= LAST_WIDE)
        else $error("byte count out of range");

    // unsigned32 values never hold more than four pending bytes
    a_u32_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_U32) |-> (r_state.cnt <= LAST_NARROW))
        else $error("unsigned32 value too long");

    // mode holds while a value is in progress
    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_state.cnt != 4'd0) |=> (r_state.mode == $past(r_state.mode)))
        else $error("mode changed mid-value");

    // a finished value restarts the decoder
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && step_done) |=> (r_state.cnt == 4'd0 && r_state.acc == 64'd0))
        else $error("decoder state not cleared after result");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.value == 64'sd0))
        else $error("nonzero value on error result");

endmodule

FILE: hw/rtl/leb_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_step
// per-byte decode: merges one byte into the decoder state, flags errors
// ----------------------------------------------------------------------------
module leb_step
    import leb_pkg::*;
(
    input  t_dec_state i_state,
    input  t_in_item   i_item,
    output t_dec_state o_state,
    output logic       o_done,
    output t_out_item  o_result
);

    logic [1:0]  mode_eff;
    logic        wide;
    logic        sgn;
    logic [3:0]  last;
    logic [3:0]  idx;
    logic        at_last;
    logic [6:0]  shift;
    logic [6:0]  payload;
    logic        cont;
    logic [2:0]  unused_n;
    logic [5:0]  unused_w;
    logic [63:0] acc_or;
    logic [63:0] acc_ext;
    logic [63:0] value;
    t_status     status;
    logic        done;

    always_comb begin
        mode_eff = (i_state.cnt == 4'd0) ? i_item.func : i_state.mode;
        wide     = mode_eff[1];
        sgn      = (mode_eff != MODE_U32);
        last     = wide ? LAST_WIDE : LAST_NARROW;
        idx      = (i_state.cnt > last) ? last : i_state.cnt;
        at_last  = (idx == last);
        // 7 * idx
        shift    = {idx, 3'b000} - {3'b000, idx};
        payload  = i_item.data_byte[6:0];
        cont     = i_item.data_byte[7];
        unused_n = payload[6:4];
        unused_w = payload[6:1];

        // unused bits of the longest byte
        status = ST_OK;
        if (at_last) begin
            if (mode_eff == MODE_U32) begin
                if (i_item.data_byte[7:4] != 4'd0) begin
                    status = ST_BAD_BITS;
                end
            end else if (!wide) begin
                if (unused_n != 3'b000 && unused_n != 3'b111) begin
                    status = ST_BAD_BITS;
                end
            end else begin
                if (unused_w != 6'b000000 && unused_w != 6'b111111) begin
                    status = ST_BAD_BITS;
                end
            end
        end

        acc_or  = i_state.acc | (64'(payload) << shift);
        acc_ext = acc_or;
        if (sgn && !at_last && payload[6]) begin
            acc_ext = acc_or | ({64{1'b1}} << (shift + 7'd7));
        end

        if (mode_eff == MODE_U32) begin
            value = {32'd0, acc_ext[31:0]};
        end else if (!wide) begin
            value = {{32{acc_ext[31]}}, acc_ext[31:0]};
        end else begin
            value = acc_ext;
        end

        done = 1'b1;
        if (status == ST_OK && cont) begin
            if (at_last) begin
                status = ST_TOO_LONG;
            end else if (i_item.final_byte) begin
                status = ST_TRUNCATED;
            end else begin
                done = 1'b0;
            end
        end

        o_done          = done;
        o_result.value  = (status == ST_OK) ? value : 64'd0;
        o_result.status = status;
        o_result.length = idx + 4'd1;

        o_state.acc  = done ? 64'd0 : acc_or;
        o_state.cnt  = done ? 4'd0 : idx + 4'd1;
        o_state.mode = mode_eff;
    end

endmodule

FILE: test/leb128_stream_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb128_stream_decoder_checker
// watches both channels, decodes every accepted byte on its own and compares
// each result transfer field by field with the oldest outstanding value
// ----------------------------------------------------------------------------
module leb128_stream_decoder_checker
    import leb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_results,
    output int        o_rejects
);

    // decoder state as the stream has left it
    logic [63:0] acc  = '0;
    logic [3:0]  cnt  = '0;
    logic [1:0]  mode = MODE_U32;

    t_out_item   decoded_q[$];
    int          mismatches = 0;
    int          results    = 0;
    int          rejects    = 0;

    task automatic decode_byte(input t_in_item it);
        logic [6:0]  payload;
        logic [6:0]  unused;
        logic [3:0]  idx;
        logic [3:0]  last;
        logic        wide;
        logic        sgn;
        logic [63:0] val;
        t_status     st;
        t_out_item   due;
        payload = it.data_byte[6:0];
        if (cnt == 4'd0) begin
            mode = it.func;
        end
        wide = (mode >= MODE_S64);
        sgn  = (mode != MODE_U32);
        last = wide ? LAST_WIDE : LAST_NARROW;
        idx  = (cnt > last) ? last : cnt;
        st   = ST_OK;
        val  = '0;
        // longest byte: bits past the value width must be a clean extension
        if (idx == last) begin
            if (mode == MODE_U32) begin
                if (it.data_byte[7:4] != 4'h0) st = ST_BAD_BITS;
            end else begin
                unused = payload & (wide ? 7'h7e : 7'h70);
                if (unused != 7'h00 && unused != (wide ? 7'h7e : 7'h70)) st = ST_BAD_BITS;
            end
        end
        if (st == ST_OK) begin
            acc |= 64'(payload) << (7 * idx);
            if (!it.data_byte[7]) begin
                if (sgn && idx < last && payload[6]) begin
                    acc |= {64{1'b1}} << (7 * idx + 7);
                end
                if (mode == MODE_U32) begin
                    val = {32'h0, acc[31:0]};
                end else if (!wide) begin
                    val = {{32{acc[31]}}, acc[31:0]};
                end else begin
                    val = acc;
                end
            end else if (idx == last) begin
                st = ST_TOO_LONG;
            end else if (it.final_byte) begin
                st = ST_TRUNCATED;
            end else begin
                cnt = idx + 4'd1;
                return;
            end
        end
        due.value  = (st == ST_OK) ? val : '0;
        due.status = st;
        due.length = idx + 4'd1;
        decoded_q.push_back(due);
        acc = '0;
        cnt = '0;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (decoded_q.size() == 0) begin
            $error("unexpected result: value %0d status %0d length %0d",
                   got.value, got.status, got.length);
            mismatches++;
            return;
        end
        want = decoded_q.pop_front();
        results++;
        if (want.status != ST_OK) rejects++;
        if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got.value);
            mismatches++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            acc  = '0;
            cnt  = '0;
            mode = MODE_U32;
            decoded_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_in_valid && !i_in_stall) decode_byte(i_in_data);
        end
        o_mismatches <= mismatches;
        o_pending    <= decoded_q.size();
        o_results    <= results;
        o_rejects    <= rejects;
    end

endmodule

FILE: test/leb128_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb128_stream_decoder_tb
// drives leb128 byte streams in all modes through the decoder: a directed
// set of boundary encodings, then mostly well-formed random values mixed
// with stray bytes, under four patterns of sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module leb128_stream_decoder_tb;
    import leb_pkg::*;

    localparam int         HALF_PERIOD_NS  = 4;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         BYTES_PER_PHASE = 375;
    // results pass the input and result registers after the ending byte, leave some slack
    localparam int         DRAIN_CYCLES    = 8;
    // the unnamed fourth mode code, decoded like signed64
    localparam logic [1:0] MODE_SPARE      = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int bytes_sent   = 0;
    int cycles       = 0;
    int mismatches;
    int pending;
    int results;
    int rejects;

    leb128_stream_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    leb128_stream_decoder_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_rejects    (rejects)
    );

    initial begin
        forever #(HALF_PERIOD_NS) clk = ~clk;
    end

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("leb128_stream_decoder_tb failed");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // one byte transfer, with an optional random gap in front of it
    task automatic send_byte(input logic [1:0] mode, input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{func: mode, data_byte: b, final_byte: fin};
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // one encoded value with random content; the func field only matters on
    // the first byte, so later bytes carry random modes
    task automatic send_value();
        logic [1:0] mode;
        logic [7:0] b;
        logic       fin;
        int         last;
        int         nbytes;
        mode   = 2'($urandom_range(3));
        last   = (mode >= MODE_S64) ? 9 : 4;
        // a quarter of the values are set to run to the longest byte; the rest draw a random length
        nbytes = ($urandom_range(3) == 0) ? last + 1 : $urandom_range(1, last + 1);
        for (int i = 0; i < nbytes; i++) begin
            fin = ($urandom_range(15) == 0);
            if (i < nbytes - 1) begin
                b = 8'h80 | 8'($urandom_range(127));
            end else if (i == last && $urandom_range(3) != 0) begin
                // longest byte with a clean extension, sometimes still continued
                b    = 8'($urandom_range(255));
                b[7] = ($urandom_range(3) == 0);
                if (mode == MODE_U32) begin
                    b[7:4] = 4'h0;
                end else if (mode == MODE_S32) begin
                    b[6:4] = {3{b[6]}};
                end else begin
                    b[6:1] = {6{b[6]}};
                end
            end else if (i == last) begin
                b = 8'($urandom_range(255));
            end else begin
                b = 8'($urandom_range(127));
            end
            send_byte((i == 0) ? mode : 2'($urandom_range(3)), b, fin);
            // a continued byte marked final truncates the value here
            if (fin && b[7]) break;
        end
    endtask

    // stray bytes, then one with bit 7 clear, which closes any open value
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_byte(2'($urandom_range(3)), 8'($urandom()), 1'($urandom()));
        send_byte(2'($urandom_range(3)), 8'($urandom_range(127)), 1'($urandom()));
    endtask

    // sender holds off until every outstanding result has been transferred
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed encodings, no gaps and no stalls
        // single unsigned byte, final set on a byte that ends the value
        send_byte(MODE_U32, 8'h7f, 1'b1);
        // unsigned fifth byte with an excess high bit
        repeat (4) send_byte(MODE_U32, 8'h80, 1'b0);
        send_byte(MODE_U32, 8'h10, 1'b0);
        // signed32 one byte with bit 6 set: -64
        send_byte(MODE_S32, 8'h40, 1'b0);
        // signed32 minimum, top byte carries all-one unused bits
        repeat (4) send_byte(MODE_S32, 8'h80, 1'b0);
        send_byte(MODE_S32, 8'h78, 1'b0);
        // signed64 minimum over the full ten bytes
        repeat (9) send_byte(MODE_S64, 8'h80, 1'b0);
        send_byte(MODE_S64, 8'h7f, 1'b0);
        // buffer ends inside a value
        send_byte(MODE_S64, 8'hff, 1'b1);
        // spare mode code behaves as signed64
        send_byte(MODE_SPARE, 8'h3f, 1'b0);
        wait_drained();

        // random traffic: free flow, slow sender, slow receiver, both light
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 59;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 59;
                end
                default: begin
                    tx_idle_pct  = 8;
                    rx_stall_pct = 8;
                end
            endcase
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target) begin
                if ($urandom_range(9) == 0) begin
                    send_noise();
                end else begin
                    send_value();
                end
            end
            wait_drained();
        end

        rx_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d stream bytes sent across four gap/stall patterns, %0d results compared",
                 bytes_sent, results);
        $display("%0d of those results flagged bad bits, overlong or truncated values",
                 rejects);
        if (mismatches == 0) begin
            $display("leb128_stream_decoder_tb passed");
        end else begin
            $display("leb128_stream_decoder_tb failed");
        end
        $finish;
    end

endmodule
